[design/fss_pkg.sv]
package fss_pkg;

    localparam int TERM_MAX = 16;
    localparam int LEN_W = $clog2(TERM_MAX + 1);
    localparam int IDX_W = $clog2(TERM_MAX);
    localparam int POS_W = 11;
    localparam int RUN_W = 5;
    localparam int SCORE_W = 11;
    localparam int CALC_W = 16;
    localparam int NEEDLE_W = 8 * TERM_MAX;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CALC_W-1:0] SCORE_BASE = CALC_W'(1000);
    localparam logic [CALC_W-1:0] PREFIX_BONUS = CALC_W'(250);
    localparam logic [CALC_W-1:0] SUBSTRING_BONUS = CALC_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic             empty;
        logic             complete;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] gap;
        logic [POS_W-1:0] length;
        logic [RUN_W-1:0] best;
        logic             prefix;
        logic             substring;
    } fss_final_t;

    function automatic logic [7:0] fss_fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[design/fuzzy_subsequence_scorer.sv]
// Scores candidate strings against a search term of up to 16 bytes.
// The term is loaded through the configuration channel: index 0 holds term
// bytes 0 to 7, index 1 holds bytes 8 to 15, and index 2 holds the length.
// Length is cfg_data[4:0]; 17 to 31 act as 16. The channel is always ready.
// Candidate characters arrive on the s_ channel, one per transfer, with
// s_last_symbol marking the final character of a string. Each string yields
// exactly one transfer on the m_ channel, carrying m_matched and m_score.
// Comparison is ASCII case-insensitive on both sides.
// The block takes one character every cycle while the receiver keeps up.
// The path has three register stages, input, match state, and result, which
// a string's last character passes through in turn. When the receiver stalls,
// the stages fill in turn and s_ready drops only once all three are occupied;
// no transfer is ever lost or repeated. Reset clears all string state and
// sets the configuration registers to an empty term, for which every string
// matches with a score of zero. Configuration is meant to be written only
// while no result is pending.
module fuzzy_subsequence_scorer
    import fss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_symbol,
    input  logic                 s_last_symbol,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_matched,
    output logic [SCORE_W-1:0]   m_score
);

    logic [63:0]      needle_low_reg;
    logic [63:0]      needle_high_reg;
    logic [4:0]       needle_len_reg;
    logic [LEN_W-1:0] term_len;
    logic             fin_valid;
    logic             fin_ready;
    fss_final_t       fin;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                CFG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                CFG_NEEDLE_LEN:  needle_len_reg  <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign term_len = (needle_len_reg > 5'(TERM_MAX)) ? LEN_W'(TERM_MAX)
                                                       : LEN_W'(needle_len_reg);

    fss_match u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol      (s_symbol),
        .s_last_symbol (s_last_symbol),
        .needle        ({needle_high_reg, needle_low_reg}),
        .term_len      (term_len),
        .fin_valid     (fin_valid),
        .fin_ready     (fin_ready),
        .fin           (fin)
    );

    fss_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_matched (m_matched),
        .m_score   (m_score)
    );

endmodule

[design/fss_match.sv]
module fss_match
    import fss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_symbol,
    input  logic                s_last_symbol,
    input  logic [NEEDLE_W-1:0] needle,
    input  logic [LEN_W-1:0]    term_len,
    output logic                fin_valid,
    input  logic                fin_ready,
    output fss_final_t          fin
);

    logic             in_valid_reg;
    logic [7:0]       sym_reg;
    logic             last_reg;
    logic             advance;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [POS_W-1:0]    first_reg, first_next;
    logic [POS_W-1:0]    prev_reg, prev_next;
    logic                any_reg, any_next;
    logic [POS_W-1:0]    gap_reg, gap_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [RUN_W-1:0]    best_reg, best_next;
    logic                prefix_reg, prefix_next;
    logic [TERM_MAX-1:0] vec_reg, vec_next;
    logic                seen_reg, seen_next;

    logic                fin_valid_reg;
    fss_final_t          fin_reg, fin_next;

    logic [7:0]          c;
    logic [TERM_MAX-1:0] eq;
    logic                hit;
    logic                contiguous;
    logic [POS_W-1:0]    gap_step;
    logic [POS_W:0]      gap_sum;
    logic [LEN_W-1:0]    len_m1;

    assign advance = in_valid_reg && (!fin_valid_reg || fin_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            sym_reg  <= s_symbol;
            last_reg <= s_last_symbol;
        end
    end

    always_comb begin
        c = fss_fold(sym_reg);
        for (int j = 0; j < TERM_MAX; j++) begin
            eq[j] = (LEN_W'(j) < term_len) && (fss_fold(needle[8*j +: 8]) == c);
        end

        pos_next    = pos_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        any_next    = any_reg;
        gap_next    = gap_reg;
        run_next    = run_reg;
        best_next   = best_reg;
        prefix_next = prefix_reg;
        vec_next    = vec_reg;
        seen_next   = seen_reg;

        hit = (idx_reg < term_len) && eq[idx_reg[IDX_W-1:0]];
        contiguous = ({1'b0, pos_reg} == {1'b0, prev_reg} + 12'd1) || (pos_reg == prev_reg);
        gap_step = (pos_reg > prev_reg) ? (pos_reg - prev_reg - 11'd1) : '0;
        gap_sum = {1'b0, gap_reg} + {1'b0, gap_step};
        len_m1 = term_len - LEN_W'(1);

        if (hit) begin
            if (!any_reg) begin
                first_next = pos_reg;
                run_next   = RUN_W'(1);
            end else if (contiguous) begin
                run_next = run_reg + RUN_W'(1);
            end else begin
                gap_next = (gap_sum > {1'b0, POS_MAX}) ? POS_MAX : gap_sum[POS_W-1:0];
                run_next = RUN_W'(1);
            end
            if (run_next > best_reg) begin
                best_next = run_next;
            end
            prev_next = pos_reg;
            any_next  = 1'b1;
            idx_next  = idx_reg + LEN_W'(1);
        end

        if ((pos_reg < POS_W'(term_len)) && !eq[pos_reg[IDX_W-1:0]]) begin
            prefix_next = 1'b0;
        end

        if (term_len != '0) begin
            vec_next = {vec_reg[TERM_MAX-2:0], 1'b1} & eq;
            if (vec_next[len_m1[IDX_W-1:0]]) begin
                seen_next = 1'b1;
            end
        end

        if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end

        fin_next.empty     = (term_len == '0);
        fin_next.complete  = (idx_next == term_len);
        fin_next.first     = first_next;
        fin_next.gap       = gap_next;
        fin_next.length    = pos_next;
        fin_next.best      = best_next;
        fin_next.prefix    = prefix_next;
        fin_next.substring = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_reg)) begin
            pos_reg    <= '0;
            idx_reg    <= '0;
            first_reg  <= '0;
            prev_reg   <= '0;
            any_reg    <= 1'b0;
            gap_reg    <= '0;
            run_reg    <= '0;
            best_reg   <= '0;
            prefix_reg <= 1'b1;
            vec_reg    <= '0;
            seen_reg   <= 1'b0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            first_reg  <= first_next;
            prev_reg   <= prev_next;
            any_reg    <= any_next;
            gap_reg    <= gap_next;
            run_reg    <= run_next;
            best_reg   <= best_next;
            prefix_reg <= prefix_next;
            vec_reg    <= vec_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (!fin_valid_reg || fin_ready) begin
            fin_valid_reg <= advance && last_reg;
        end
        if (advance && last_reg) begin
            fin_reg <= fin_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

[design/fss_score.sv]
module fss_score
    import fss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fin_valid,
    output logic               fin_ready,
    input  fss_final_t         fin,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_matched,
    output logic [SCORE_W-1:0] m_score
);

    logic               m_valid_reg;
    logic               matched_reg, matched_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [CALC_W-1:0]  gain;
    logic [CALC_W-1:0]  loss;
    logic [CALC_W-1:0]  diff;

    assign fin_ready = !m_valid_reg || m_ready;

    always_comb begin
        gain = SCORE_BASE
             + (fin.prefix ? PREFIX_BONUS : '0)
             + (fin.substring ? SUBSTRING_BONUS : '0)
             + {{(CALC_W-RUN_W-3){1'b0}}, fin.best, 3'b000}
             + {{(CALC_W-RUN_W-2){1'b0}}, fin.best, 2'b00};
        loss = {{(CALC_W-POS_W-3){1'b0}}, fin.first, 3'b000}
             + {{(CALC_W-POS_W-1){1'b0}}, fin.gap, 1'b0}
             + {{(CALC_W-POS_W){1'b0}}, fin.gap}
             + {{(CALC_W-POS_W){1'b0}}, fin.length};
        diff = gain - loss;

        matched_next = 1'b0;
        score_next   = '0;
        if (fin.empty) begin
            matched_next = 1'b1;
        end else if (fin.complete && (gain >= loss)) begin
            matched_next = 1'b1;
            score_next   = diff[SCORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            m_valid_reg <= fin_valid;
        end
        if (fin_valid && fin_ready) begin
            matched_reg <= matched_next;
            score_reg   <= score_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = matched_reg;
    assign m_score   = score_reg;

endmodule
